// ----- design/scba_pkg.sv -----
// ----------------------------------------------------------------------------
// scba_pkg: shared types and constants of the size-class block allocator
// Defaults for the top-level parameters, status and register codes, states.
// ----------------------------------------------------------------------------
`default_nettype none

package scba_pkg;

	localparam int PAGES_DEF      = 16;
	localparam int PAGE_BYTES_DEF = 4096;
	localparam int MIN_BLOCK_DEF  = 8;
	localparam int MAX_BLOCK_DEF  = 2048;

	localparam int ADDR_W  = 32;
	localparam int SIZE_W  = 12;
	localparam int PCNT_W  = 5;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 1;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_ZERO  = 2'd1;
	localparam status_t ST_NONE  = 2'd2;
	localparam status_t ST_RANGE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT  = 1'b1;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_ALLOC  = 8'b0000_0010,
		S_SEARCH = 8'b0000_0100,
		S_POP    = 8'b0000_1000,
		S_CARVE  = 8'b0001_0000,
		S_FREE   = 8'b0010_0000,
		S_PURGE  = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

// ----- design/scba_req_if.sv -----
// ----------------------------------------------------------------------------
// scba_req_if: request channel of the allocator
// Valid/ready handshake carrying mode, size and address.
// ----------------------------------------------------------------------------
`default_nettype none

interface scba_req_if import scba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [SIZE_W-1:0] size;
	logic [ADDR_W-1:0] address;

	modport source (output valid, mode, size, address, input ready);
	modport sink (input valid, mode, size, address, output ready);
endinterface

`default_nettype wire

// ----- design/scba_rsp_if.sv -----
// ----------------------------------------------------------------------------
// scba_rsp_if: response channel of the allocator
// Valid/ready handshake carrying block address, class bytes, release, status.
// ----------------------------------------------------------------------------
`default_nettype none

interface scba_rsp_if import scba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] block_address;
	logic [SIZE_W-1:0] block_bytes;
	logic              page_released;
	status_t           status;

	modport source (output valid, block_address, block_bytes, page_released, status,
		input ready);
	modport sink (input valid, block_address, block_bytes, page_released, status,
		output ready);
endinterface

`default_nettype wire

// ----- design/scba_ram.sv -----
// ----------------------------------------------------------------------------
// scba_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module scba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/size_class_block_allocator_top.sv -----
// ----------------------------------------------------------------------------
// size_class_block_allocator_top: power-of-two size-class block allocator
// Free blocks of each class sit in a ring queue inside one RAM; pages are
// carved on demand from a free-page FIFO and returned when wholly free.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | word
//  req     | in  | valid/ready       | mode, size, address
//  rsp     | out | valid/ready       | block_address, block_bytes, page_released, status
//  cfg     | in  | cfg_we (no wait)  | cfg_index, cfg_data
//
//  Steps: errors go from decode straight to the response; a queue pop reads
//  the head entry, then pops it; a larger-class search tries one class at a
//  time; carving pushes the page's other (PAGE_BYTES/class - 1) blocks one by
//  one; a page release walks the class queue once, one entry per cycle. The
//  single queue RAM port pair sets this pace. Reset or any config write
//  reinitializes counts, pages and FIFO at once; the queue RAM needs no
//  clearing pass. A stalled rsp holds its word while the next request is taken.
`default_nettype none

module size_class_block_allocator_top import scba_pkg::*; #(
	parameter int PAGES      = PAGES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF,
	parameter int MIN_BLOCK  = MIN_BLOCK_DEF,
	parameter int MAX_BLOCK  = MAX_BLOCK_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	scba_req_if.sink                  req,
	scba_rsp_if.source                rsp
);

	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int FCW   = $clog2(PAGES + 1);
	localparam int PBW   = $clog2(PAGE_BYTES);
	localparam int NCLS  = $clog2(MAX_BLOCK / MIN_BLOCK) + 1;
	localparam int KW    = (NCLS > 1) ? $clog2(NCLS) : 1;
	localparam int CCW   = $clog2(NCLS + 1);
	localparam int OFFW  = $clog2(PAGES * PAGE_BYTES);
	localparam int QCAP  = PAGES * (PAGE_BYTES / MIN_BLOCK);
	localparam int QW    = $clog2(QCAP);
	localparam int CW    = $clog2(QCAP + 1);
	localparam int BPP   = PAGE_BYTES / MIN_BLOCK;
	localparam int NW    = $clog2(BPP + 1);
	localparam int RAW   = KW + QW;
	localparam int RDEPTH = 2 ** RAW;

	// configuration
	logic [ADDR_W-1:0] base_q;
	logic [PCNT_W-1:0] page_count_q;
	logic [FCW-1:0]    pages_used;

	// per-class queue pointers, per-page bookkeeping, free-page FIFO
	logic [QW-1:0]  head_q [NCLS];
	logic [CW-1:0]  cnt_q  [NCLS];
	logic [CCW-1:0] pclass_q [PAGES];
	logic [NW-1:0]  pfc_q    [PAGES];
	logic [PW-1:0]  fifo_q   [PAGES];
	logic [PW-1:0]  fhead_q;
	logic [FCW-1:0] fcnt_q;

	state_t state_q;

	// latched request
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;

	// work registers
	logic [KW-1:0]   cls_q;
	logic [KW-1:0]   c_q;
	logic [PW-1:0]   pg_q;
	logic [OFFW-1:0] carve_off_q;
	logic [OFFW-1:0] r_q;
	logic [NW-1:0]   left_q;
	logic [CW-1:0]   i_q;
	logic [CW-1:0]   kept_q;
	logic            pend_s1;

	// result, then output register
	logic [ADDR_W-1:0] res_addr_q;
	logic [SIZE_W-1:0] res_bytes_q;
	logic              res_rel_q;
	status_t           res_st_q;
	logic              ov_q;
	logic [ADDR_W-1:0] o_addr_q;
	logic [SIZE_W-1:0] o_bytes_q;
	logic              o_rel_q;
	status_t           o_st_q;

	// RAM ports
	logic            ram_we, ram_re;
	logic [RAW-1:0]  ram_waddr, ram_raddr;
	logic [OFFW-1:0] ram_wdata, ram_rdata;

	// decode
	logic [KW-1:0]  a_k;
	logic           a_zero, a_range;
	logic [ADDR_W-1:0] f_off;
	logic [ADDR_W-1:0] f_pgfull;
	logic [PW-1:0]  f_p;
	logic           f_bad;
	logic [KW-1:0]  f_k;
	logic [CCW-1:0] f_pc;
	logic [NW-1:0]  f_pfnew;
	logic [NW-1:0]  f_n;
	logic [NW-1:0]  a_n;
	logic [KW-1:0]  qsel;
	logic [QW-1:0]  q_head;
	logic [CW-1:0]  q_cnt;
	logic [PW-1:0]  pop_p;
	logic [PW-1:0]  psel;
	logic [PW-1:0]  ftail;
	logic [FCW:0]   ftail_sum;
	logic           accept;
	logic           out_free;

	function automatic logic [KW-1:0] class_of(input logic [SIZE_W-1:0] sz);
		logic [KW-1:0] k;
		k = KW'(NCLS - 1);
		for (int j = NCLS - 1; j >= 0; j--) begin
			if (32'(sz) <= (32'(MIN_BLOCK) << j)) begin
				k = KW'(j);
			end
		end
		return k;
	endfunction

	scba_ram #(.WIDTH(OFFW), .DEPTH(RDEPTH)) u_queue_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign pages_used = (32'(page_count_q) > 32'(PAGES)) ? FCW'(PAGES) : FCW'(page_count_q);
	assign accept     = req.valid && req.ready;
	assign out_free   = !ov_q || rsp.ready;
	assign req.ready  = (state_q == S_IDLE);

	always_comb begin
		a_k     = class_of(size_q);
		a_zero  = (size_q == '0);
		a_range = (32'(size_q) > 32'(MAX_BLOCK)) ||
			((32'(MIN_BLOCK) << a_k) > 32'(PAGE_BYTES));
		a_n     = NW'(BPP >> a_k);

		f_off    = addr_q - base_q;
		f_pgfull = f_off >> PBW;
		f_p      = PW'(f_pgfull);
		pop_p    = PW'(ram_rdata >> PBW);
		psel     = (state_q == S_FREE) ? f_p : pop_p;
		f_pc     = pclass_q[psel];
		f_k      = KW'(f_pc - CCW'(1));
		f_n      = NW'(BPP >> f_k);
		f_pfnew  = pfc_q[psel] + NW'(1);
		f_bad    = (addr_q < base_q) || (f_pgfull >= 32'(pages_used)) || (f_pc == '0) ||
			((f_off & ((32'(MIN_BLOCK) << f_k) - 32'd1)) != '0);

		unique case (state_q)
			S_ALLOC:  qsel = a_k;
			S_FREE:   qsel = f_k;
			S_SEARCH: qsel = c_q;
			default:  qsel = cls_q;
		endcase
		q_head = head_q[qsel];
		q_cnt  = cnt_q[qsel];

		ftail_sum = (FCW+1)'(fhead_q) + (FCW+1)'(fcnt_q);
		ftail     = (ftail_sum >= (FCW+1)'(PAGES)) ? PW'(ftail_sum - (FCW+1)'(PAGES))
			: PW'(ftail_sum);

		ram_we    = 1'b0;
		ram_waddr = {qsel, QW'(q_head + QW'(q_cnt))};
		ram_wdata = carve_off_q;
		ram_re    = 1'b0;
		ram_raddr = {qsel, q_head};
		unique case (state_q)
			S_ALLOC: begin
				ram_re = !a_zero && !a_range && (q_cnt != '0);
			end
			S_SEARCH: begin
				ram_re = (q_cnt != '0);
			end
			S_CARVE: begin
				ram_we = (left_q != '0);
			end
			S_FREE: begin
				ram_we    = !f_bad && (f_pfnew < f_n);
				ram_wdata = OFFW'(f_off);
			end
			S_PURGE: begin
				ram_re    = (i_q < q_cnt);
				ram_raddr = {qsel, QW'(q_head + QW'(i_q))};
				ram_we    = pend_s1 && (pop_p != pg_q);
				ram_waddr = {qsel, QW'(q_head + QW'(kept_q))};
				ram_wdata = ram_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			page_count_q <= PCNT_W'(16);
			for (int i = 0; i < NCLS; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			for (int i = 0; i < PAGES; i++) begin
				pclass_q[i] <= '0;
				pfc_q[i]    <= '0;
				fifo_q[i]   <= PW'(i);
			end
			fhead_q <= '0;
			fcnt_q  <= (PAGES > 16) ? FCW'(16) : FCW'(PAGES);
			state_q <= S_IDLE;
			pend_s1 <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_REGION_BASE: base_q <= cfg_data;
					CFG_PAGE_COUNT:  page_count_q <= cfg_data[PCNT_W-1:0];
					default: ;
				endcase
				// reinitialize as reset does, with the new page count
				for (int i = 0; i < NCLS; i++) begin
					head_q[i] <= '0;
					cnt_q[i]  <= '0;
				end
				for (int i = 0; i < PAGES; i++) begin
					pclass_q[i] <= '0;
					pfc_q[i]    <= '0;
					fifo_q[i]   <= PW'(i);
				end
				fhead_q <= '0;
				if (cfg_index == CFG_PAGE_COUNT) begin
					fcnt_q <= (32'(cfg_data[PCNT_W-1:0]) > 32'(PAGES)) ? FCW'(PAGES)
						: FCW'(cfg_data[PCNT_W-1:0]);
				end else begin
					fcnt_q <= pages_used;
				end
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept) begin
							size_q      <= req.size;
							addr_q      <= req.address;
							res_addr_q  <= '0;
							res_bytes_q <= '0;
							res_rel_q   <= 1'b0;
							res_st_q    <= ST_OK;
							state_q     <= (req.mode == MODE_FREE) ? S_FREE : S_ALLOC;
						end
					end
					S_ALLOC: begin
						cls_q <= a_k;
						r_q   <= OFFW'(32'(MIN_BLOCK) << a_k);
						if (a_zero) begin
							res_st_q <= ST_ZERO;
							state_q  <= S_DONE;
						end else if (a_range) begin
							res_st_q <= ST_RANGE;
							state_q  <= S_DONE;
						end else if (q_cnt != '0) begin
							state_q <= S_POP;
						end else if (fcnt_q != '0) begin
							// carve the oldest free page; hand out its first block
							pg_q               <= fifo_q[fhead_q];
							pclass_q[fifo_q[fhead_q]] <= CCW'(a_k) + CCW'(1);
							pfc_q[fifo_q[fhead_q]]    <= a_n - NW'(1);
							fhead_q <= (32'(fhead_q) == PAGES - 1) ? '0 : fhead_q + PW'(1);
							fcnt_q  <= fcnt_q - FCW'(1);
							carve_off_q <= (OFFW'(fifo_q[fhead_q]) << PBW) +
								OFFW'(32'(MIN_BLOCK) << a_k);
							left_q      <= a_n - NW'(1);
							res_addr_q  <= base_q + (ADDR_W'(fifo_q[fhead_q]) << PBW);
							res_bytes_q <= SIZE_W'(32'(MIN_BLOCK) << a_k);
							state_q     <= S_CARVE;
						end else if (32'(a_k) + 1 < NCLS) begin
							c_q     <= a_k + KW'(1);
							state_q <= S_SEARCH;
						end else begin
							res_st_q <= ST_NONE;
							state_q  <= S_DONE;
						end
					end
					S_SEARCH: begin
						// take an unsplit block from the next larger non-empty class
						if (q_cnt != '0) begin
							cls_q   <= c_q;
							state_q <= S_POP;
						end else if (32'(c_q) == NCLS - 1) begin
							res_st_q <= ST_NONE;
							state_q  <= S_DONE;
						end else begin
							c_q <= c_q + KW'(1);
						end
					end
					S_POP: begin
						head_q[cls_q] <= q_head + QW'(1);
						cnt_q[cls_q]  <= q_cnt - CW'(1);
						pfc_q[pop_p]  <= pfc_q[pop_p] - NW'(1);
						res_addr_q    <= base_q + ADDR_W'(ram_rdata);
						res_bytes_q   <= SIZE_W'(32'(MIN_BLOCK) << cls_q);
						state_q       <= S_DONE;
					end
					S_CARVE: begin
						if (left_q != '0) begin
							cnt_q[cls_q] <= q_cnt + CW'(1);
							carve_off_q  <= carve_off_q + r_q;
							left_q       <= left_q - NW'(1);
						end else begin
							state_q <= S_DONE;
						end
					end
					S_FREE: begin
						if (f_bad) begin
							res_st_q <= ST_RANGE;
							state_q  <= S_DONE;
						end else begin
							res_bytes_q <= SIZE_W'(32'(MIN_BLOCK) << f_k);
							cls_q       <= f_k;
							if (f_pfnew < f_n) begin
								cnt_q[f_k] <= q_cnt + CW'(1);
								pfc_q[f_p] <= f_pfnew;
								state_q    <= S_DONE;
							end else begin
								// page wholly free: drop its blocks, return the page
								pclass_q[f_p] <= '0;
								pfc_q[f_p]    <= '0;
								if (32'(fcnt_q) < PAGES) begin
									fifo_q[ftail] <= f_p;
									fcnt_q        <= fcnt_q + FCW'(1);
								end
								res_rel_q <= 1'b1;
								pg_q      <= f_p;
								i_q       <= '0;
								kept_q    <= '0;
								pend_s1   <= 1'b0;
								state_q   <= S_PURGE;
							end
						end
					end
					S_PURGE: begin
						pend_s1 <= ram_re;
						if (ram_re) begin
							i_q <= i_q + CW'(1);
						end
						if (ram_we) begin
							kept_q <= kept_q + CW'(1);
						end
						if (!ram_re && !pend_s1) begin
							cnt_q[cls_q] <= kept_q;
							state_q      <= S_DONE;
						end
					end
					S_DONE: begin
						if (out_free) begin
							ov_q      <= 1'b1;
							o_addr_q  <= res_addr_q;
							o_bytes_q <= res_bytes_q;
							o_rel_q   <= res_rel_q;
							o_st_q    <= res_st_q;
							state_q   <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign rsp.valid         = ov_q;
	assign rsp.block_address = o_addr_q;
	assign rsp.block_bytes   = o_bytes_q;
	assign rsp.page_released = o_rel_q;
	assign rsp.status        = o_st_q;

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fcnt_q) <= PAGES)
		else $error("free-page count exceeds page total");

	a_purge_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PURGE) |-> (kept_q <= i_q))
		else $error("purge write index passed read index");

	a_ram_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("queue RAM read and write hit one entry");

	a_accept_leave: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_we) |=> (state_q != S_IDLE))
		else $error("accepted word not processed");

endmodule

`default_nettype wire

// ----- test/tb_size_class_block_allocator_top.sv -----
// ----------------------------------------------------------------------------
// tb_size_class_block_allocator_top: regression bench of the block allocator
// Drives requests and register writes, models the class queues, the page
// FIFO and the per-page counts, and checks every response word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_size_class_block_allocator_top;
	import scba_pkg::*;

	localparam int NPAGES    = PAGES_DEF;
	localparam int PG_BYTES  = PAGE_BYTES_DEF;
	localparam int MINB      = MIN_BLOCK_DEF;
	localparam int MAXB      = MAX_BLOCK_DEF;
	localparam int NCLASS    = 12;
	localparam int QUEUE_CAP = NPAGES * (PG_BYTES / MINB);
	localparam int LIMIT     = 50_000_000;

	typedef struct packed {
		logic [ADDR_W-1:0] block_address;
		logic [SIZE_W-1:0] block_bytes;
		logic              page_released;
		status_t           status;
	} rsp_word_t;

	// Allocator model plus the in-order list of response words still due.
	class alloc_scoreboard;
		bit [31:0]   base;
		int          pcount;
		int unsigned class_q[NCLASS][$];
		int          page_cls[NPAGES];
		int          page_free[NPAGES];
		int          page_fifo[NPAGES];
		int          fifo_head, fifo_cnt;
		rsp_word_t   due[$];
		bit [31:0]   held[$];
		int          errors, checked, released, failed;

		function void reinit();
			for (int k = 0; k < NCLASS; k++) class_q[k].delete();
			for (int i = 0; i < NPAGES; i++) begin
				page_cls[i] = 0;
				page_free[i] = 0;
				page_fifo[i] = i;
			end
			fifo_head = 0;
			fifo_cnt = (pcount > NPAGES) ? NPAGES : pcount;
			held.delete();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == CFG_REGION_BASE) base = val;
			else pcount = int'(val[PCNT_W-1:0]);
			reinit();
		endfunction

		function int cls_index(int bytes);
			int k, r;
			k = 0;
			r = MINB;
			while (r < bytes) begin
				r = r << 1;
				k++;
			end
			return k;
		endfunction

		function int unsigned pop_class(int k);
			int unsigned off;
			int p;
			off = class_q[k].pop_front();
			p = (off / PG_BYTES) % NPAGES;
			page_free[p]--;
			return off;
		endfunction

		function rsp_word_t predict_alloc(int size);
			rsp_word_t w;
			int r, k, p, n, cs;
			int unsigned off;
			w = '0;
			if (size == 0) begin
				w.status = ST_ZERO;
				return w;
			end
			if (size > MAXB) begin
				w.status = ST_RANGE;
				return w;
			end
			r = MINB;
			while (r < size) r = r << 1;
			k = cls_index(r);
			if (class_q[k].size() != 0) begin
				off = pop_class(k);
				w.block_address = base + off;
				w.block_bytes = SIZE_W'(r);
				return w;
			end
			if (fifo_cnt != 0) begin
				p = page_fifo[fifo_head];
				fifo_head = (fifo_head + 1) % NPAGES;
				fifo_cnt--;
				n = PG_BYTES / r;
				page_cls[p] = r;
				page_free[p] = n - 1;
				for (int b = 1; b < n; b++)
					if (class_q[k].size() < QUEUE_CAP)
						class_q[k].push_back(p * PG_BYTES + b * r);
				w.block_address = base + p * PG_BYTES;
				w.block_bytes = SIZE_W'(r);
				return w;
			end
			// no page left: borrow an unsplit block of a larger class
			cs = r << 1;
			for (int c = k + 1; c < NCLASS && cs <= MAXB; c++) begin
				if (class_q[c].size() != 0) begin
					off = pop_class(c);
					w.block_address = base + off;
					w.block_bytes = SIZE_W'(cs);
					return w;
				end
				cs = cs << 1;
			end
			w.status = ST_NONE;
			return w;
		endfunction

		function rsp_word_t predict_free(bit [31:0] addr);
			rsp_word_t w;
			bit [31:0] off;
			int p, cls, k, used;
			int unsigned kept[$];
			w = '0;
			used = (pcount > NPAGES) ? NPAGES : pcount;
			if (addr < base) begin
				w.status = ST_RANGE;
				return w;
			end
			off = addr - base;
			if ((off / PG_BYTES) >= used) begin
				w.status = ST_RANGE;
				return w;
			end
			p = off / PG_BYTES;
			cls = page_cls[p];
			if (cls == 0 || ((off % PG_BYTES) % cls) != 0) begin
				w.status = ST_RANGE;
				return w;
			end
			k = cls_index(cls);
			if (class_q[k].size() < QUEUE_CAP) class_q[k].push_back(off);
			page_free[p]++;
			w.block_bytes = SIZE_W'(cls);
			if (page_free[p] >= PG_BYTES / cls) begin
				// purge every block of the page, keep the others in order
				for (int i = 0; i < class_q[k].size(); i++)
					if (class_q[k][i] / PG_BYTES != p) kept.push_back(class_q[k][i]);
				class_q[k] = kept;
				page_cls[p] = 0;
				page_free[p] = 0;
				if (fifo_cnt < NPAGES) begin
					page_fifo[(fifo_head + fifo_cnt) % NPAGES] = p;
					fifo_cnt++;
				end
				w.page_released = 1'b1;
			end
			return w;
		endfunction

		function void note_req(logic mode, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
			rsp_word_t w;
			if (mode == MODE_ALLOC) begin
				w = predict_alloc(int'(size));
				if (w.status == ST_OK) held.push_back(w.block_address);
			end else begin
				w = predict_free(addr);
			end
			if (w.page_released) released++;
			if (w.status != ST_OK) failed++;
			due.push_back(w);
		endfunction

		function void check_rsp(rsp_word_t got);
			rsp_word_t exp_w;
			checked++;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected response word %h", got);
				return;
			end
			exp_w = due.pop_front();
			if (got !== exp_w) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: exp addr %h bytes %0d rel %0d st %0d, ",
						"got addr %h bytes %0d rel %0d st %0d"},
						exp_w.block_address, exp_w.block_bytes, exp_w.page_released,
						exp_w.status, got.block_address, got.block_bytes,
						got.page_released, got.status);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   cycles = 0;
	alloc_scoreboard      sb;

	scba_req_if req ();
	scba_rsp_if rsp ();

	size_class_block_allocator_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Watchdog: end the run if the bench hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Check every accepted response word against the oldest prediction.
	always @(posedge clk)
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_rsp({rsp.block_address, rsp.block_bytes, rsp.page_released, rsp.status});

	// Stall the response side at random, changing only at the falling edge.
	initial begin
		int stall;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = pick_gap();
			rsp.ready = (stall == 0);
			repeat (stall) @(negedge clk);
			rsp.ready = 1'b1;
		end
	end

	// Present one word, hold it until taken, then note it in the model.
	task automatic send_req(logic mode, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
		int gap;
		@(negedge clk);
		req.valid = 1'b1;
		req.mode = mode;
		req.size = size;
		req.address = addr;
		do @(posedge clk); while (!req.ready);
		sb.note_req(mode, size, addr);
		gap = pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			req.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Hold off until every predicted word has come back, then settle.
	task automatic drain();
		@(negedge clk);
		req.valid = 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, val);
	endtask

	// Random mix: mostly allocations of large classes and frees of held blocks,
	// with double frees and garbage addresses and sizes as noise.
	task automatic random_items(int count);
		int r, i;
		logic [SIZE_W-1:0] sz;
		logic [ADDR_W-1:0] ad;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 48 || (r < 90 && sb.held.size() == 0)) begin
				r = $urandom_range(0, 99);
				if (r < 70) sz = SIZE_W'($urandom_range(257, MAXB));
				else if (r < 88) sz = SIZE_W'($urandom_range(1, 256));
				else if (r < 93) sz = '0;
				else sz = SIZE_W'($urandom_range(0, 4095));
				send_req(MODE_ALLOC, sz, $urandom());
			end else if (r < 90) begin
				i = $urandom_range(0, sb.held.size() - 1);
				ad = sb.held[i];
				if ($urandom_range(0, 9) != 0) sb.held.delete(i);
				send_req(MODE_FREE, SIZE_W'($urandom()), ad);
			end else begin
				if ($urandom_range(0, 1))
					ad = sb.base + ($urandom_range(0, 20 * PG_BYTES) & ~32'h7);
				else ad = $urandom();
				send_req(MODE_FREE, SIZE_W'($urandom()), ad);
			end
		end
	endtask

	initial begin
		sb = new();
		sb.base = '0;
		sb.pcount = NPAGES;
		sb.reinit();
		cfg_we = 1'b0;
		cfg_index = CFG_REGION_BASE;
		cfg_data = '0;
		req.valid = 1'b0;
		req.mode = MODE_ALLOC;
		req.size = '0;
		req.address = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: size extremes, bad frees, carving, larger-class borrowing.
		send_req(MODE_ALLOC, 12'd0, '0);
		send_req(MODE_ALLOC, 12'd4095, '0);
		send_req(MODE_ALLOC, 12'd2049, '0);
		send_req(MODE_ALLOC, 12'd1, '0);
		send_req(MODE_ALLOC, 12'd8, '0);
		send_req(MODE_ALLOC, 12'd9, '0);
		send_req(MODE_ALLOC, 12'd2048, '0);
		send_req(MODE_FREE, '0, 32'd8 * PG_BYTES);
		send_req(MODE_FREE, '0, 32'd3 * PG_BYTES + 5);
		send_req(MODE_FREE, '0, 32'hFFFF_FFFF);
		send_req(MODE_FREE, '0, 32'd16);
		send_req(MODE_FREE, '0, 32'd16);
		send_req(MODE_FREE, '0, 32'd3 * PG_BYTES);
		send_req(MODE_FREE, '0, 32'd3 * PG_BYTES + 2048);
		write_reg(CFG_PAGE_COUNT, 32'd1);
		send_req(MODE_ALLOC, 12'd2048, '0);
		send_req(MODE_ALLOC, 12'd1000, '0);
		send_req(MODE_ALLOC, 12'd5, '0);
		send_req(MODE_FREE, '0, 32'd0);
		send_req(MODE_ALLOC, 12'd100, '0);
		write_reg(CFG_PAGE_COUNT, 32'd0);
		send_req(MODE_ALLOC, 12'd64, '0);
		send_req(MODE_FREE, '0, 32'd0);

		// Random phases over several register settings, extremes included.
		write_reg(CFG_REGION_BASE, 32'h1000_0000);
		write_reg(CFG_PAGE_COUNT, 32'd16);
		random_items(60);
		drain();
		random_items(30);
		write_reg(CFG_PAGE_COUNT, 32'd2);
		random_items(80);
		write_reg(CFG_REGION_BASE, 32'hFFFF_FFFF);
		random_items(60);
		write_reg(CFG_PAGE_COUNT, 32'd31);
		write_reg(CFG_REGION_BASE, 32'hFFFF_8000);
		random_items(90);
		write_reg(CFG_REGION_BASE, 32'd0);
		write_reg(CFG_PAGE_COUNT, 32'd0);
		random_items(30);
		write_reg(CFG_PAGE_COUNT, 32'd4);
		random_items(130);

		drain();
		repeat (64) @(posedge clk);
		if (sb.due.size() != 0) sb.errors++;
		$display("checked %0d response words, %0d page releases, %0d error statuses",
			sb.checked, sb.released, sb.failed);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
design/scba_pkg.sv
design/scba_req_if.sv
design/scba_rsp_if.sv
design/scba_ram.sv
design/size_class_block_allocator_top.sv
test/tb_size_class_block_allocator_top.sv
